### rtl/adc_temperature_readout_with_deadband_unit_assert.svh
// Assertion macros shared by the readout RTL.
`ifndef ADC_TEMPERATURE_READOUT_WITH_DEADBAND_UNIT_ASSERT_SVH
`define ADC_TEMPERATURE_READOUT_WITH_DEADBAND_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define ATR_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define ATR_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/atr_pkg.sv
// Types and constants for the ADC temperature readout.
`timescale 1ns / 1ps
`default_nettype none

package atr_pkg;

	localparam int unsigned TEMP_W    = 10;
	localparam int unsigned TMAG_W    = 12;
	localparam int unsigned TENTHS_W  = 13;
	localparam int unsigned WHOLE_W   = 9;
	localparam int unsigned DIGIT_W   = 4;
	localparam int unsigned CFG_IDX_W = 3;

	localparam int F_OFFSET    = 32;
	localparam int TENTHS_MUL  = 50;
	localparam int DIV_NINE    = 9;
	localparam int DIV_TEN     = 10;

	localparam int DEADBAND_RST = 8;
	localparam int ADC_MIN_RST  = 0;
	localparam int ADC_MAX_RST  = 3850;
	localparam int TEMP_LOW_RST = -40;
	localparam int TEMP_HIGH_RST = 140;

	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ADC_MIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ADC_MAX   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LOW  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_HIGH = 3'd4;

	typedef enum logic {
		OP_MUL,
		OP_DIV
	} arith_op_t;

	typedef struct packed {
		logic      start;
		arith_op_t op;
	} arith_ctl_t;

	typedef enum logic [3:0] {
		ST_ACC,
		ST_AVG,
		ST_MAP_MUL,
		ST_MAP_DIV,
		ST_DECIDE,
		ST_TEN_MUL,
		ST_TEN_DIV,
		ST_DIV10,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

### rtl/atr_serial_arith.sv
// Shared bit-serial shift-add multiplier and restoring divider.
`timescale 1ns / 1ps
`default_nettype none

module atr_serial_arith import atr_pkg::*; #(
	parameter int unsigned W   = 22,
	parameter int unsigned DVW = 12
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire arith_ctl_t     ctl,
	input  wire logic [W-1:0]   opnd_a,
	input  wire logic [DVW-1:0] opnd_b,
	output logic                done,
	output logic [W-1:0]        quotient,
	output logic [DVW-1:0]      remainder
);

	localparam int unsigned CNT_W = $clog2(W + 1);

	arith_op_t      op_q;
	logic [CNT_W-1:0] cnt_q;
	logic           done_q;
	logic [W-1:0]   x_q;   // dividend/quotient, or product accumulator
	logic [W-1:0]   y_q;   // multiplicand, shifted left each step
	logic [DVW-1:0] z_q;   // divisor, or multiplier shifted right
	logic [DVW-1:0] rem_q;

	logic [DVW:0]   trial;
	logic [DVW:0]   trial_diff;
	logic           ge;
	logic [DVW-1:0] rem_nxt;

	assign trial      = {rem_q, x_q[W-1]};
	assign trial_diff = trial - {1'b0, z_q};
	assign ge         = trial >= {1'b0, z_q};
	// remainder stays below divisor, so the kept trial fits DVW bits
	assign rem_nxt    = ge ? trial_diff[DVW-1:0] : trial[DVW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= OP_MUL;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				op_q  <= ctl.op;
				cnt_q <= (ctl.op == OP_DIV) ? CNT_W'(W) : CNT_W'(DVW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q   <= (ctl.op == OP_DIV) ? opnd_a : '0;
			y_q   <= opnd_a;
			z_q   <= opnd_b;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			if (op_q == OP_DIV) begin
				x_q   <= {x_q[W-2:0], ge};
				rem_q <= rem_nxt;
			end else begin
				if (z_q[0]) begin
					x_q <= x_q + y_q;
				end
				y_q <= {y_q[W-2:0], 1'b0};
				z_q <= {1'b0, z_q[DVW-1:1]};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = x_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

### rtl/adc_temperature_readout_with_deadband_unit.sv
// Top level of the ADC temperature readout with change deadband.
//
// Samples arrive on in_valid/in_ready with one reading on sample. Every
// SAMPLES requests are summed; a non-closing sample only adds to the sum.
// The request that closes a window starts a chain of serial operations on
// one shared shift-add multiplier / restoring divider: window average,
// span multiply and divide, tenths multiply, divide by nine, divide by ten.
// in_ready is low while the chain runs. A suppressed window returns to
// sampling after the compare, and an empty span skips the map.
// A result sits in an output register under out_valid until out_ready; a
// stalled receiver only holds the next window's result at its last step.
// Configuration writes on cfg_valid/cfg_index/cfg_data are always taken
// (cfg_ready high) and are meant for idle periods.
// Reset clears the window, the last emitted reference and the output flag,
// and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "adc_temperature_readout_with_deadband_unit_assert.svh"

module adc_temperature_readout_with_deadband_unit import atr_pkg::*; #(
	parameter int unsigned SAMPLES  = 16,
	parameter int unsigned ADC_BITS = 12,
	localparam int unsigned DVW     = (ADC_BITS > TEMP_W) ? ADC_BITS : TEMP_W
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [ADC_BITS-1:0]  sample,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [ADC_BITS-1:0]       average_counts,
	output logic signed [TEMP_W-1:0]  fahrenheit,
	output logic signed [TEMP_W-1:0]  celsius,
	output logic signed [TENTHS_W-1:0] celsius_tenths,
	output logic                      tenths_negative,
	output logic [WHOLE_W-1:0]        whole_degrees,
	output logic [DIGIT_W-1:0]        tenth_digit,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DVW-1:0]       cfg_data
);

	localparam int unsigned SUM_W = ADC_BITS + $clog2(SAMPLES);
	localparam int unsigned IDX_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
	localparam int unsigned MUL_W = ADC_BITS + TEMP_W;
	localparam int unsigned W     = (SUM_W > MUL_W) ? SUM_W : MUL_W;

	// configuration
	logic [ADC_BITS-1:0]      deadband_q;
	logic [ADC_BITS-1:0]      adc_min_q;
	logic [ADC_BITS-1:0]      adc_max_q;
	logic signed [TEMP_W-1:0] temp_low_q;
	logic signed [TEMP_W-1:0] temp_high_q;

	// control state
	state_t              state_q, state_nxt;
	logic [SUM_W-1:0]    sum_q;
	logic [IDX_W-1:0]    idx_q;
	logic [ADC_BITS-1:0] last_counts_q;
	logic [TEMP_W-1:0]   last_f_q;
	logic                emitted_q;
	logic                out_valid_q;

	// working payload
	logic [ADC_BITS-1:0]      avg_q;
	logic signed [TEMP_W-1:0] f_q;
	logic                     g_neg_q;
	logic [TMAG_W-1:0]        tmag_q;

	// output register
	logic [ADC_BITS-1:0]        avg_out_q;
	logic [TEMP_W-1:0]          f_out_q;
	logic [TEMP_W-1:0]          c_out_q;
	logic [TENTHS_W-1:0]        tenths_out_q;
	logic                       tneg_out_q;
	logic [WHOLE_W-1:0]         whole_out_q;
	logic [DIGIT_W-1:0]         digit_out_q;

	// arithmetic unit
	arith_ctl_t     ctl;
	logic [W-1:0]   opnd_a;
	logic [DVW-1:0] opnd_b;
	logic           done;
	logic [W-1:0]   quot;
	logic [DVW-1:0] rem;

	logic                in_accept;
	logic                closing;
	logic [SUM_W-1:0]    sum_next;
	logic [ADC_BITS-1:0] avg_w;
	logic                span_ok;
	logic [ADC_BITS-1:0] span;
	logic [ADC_BITS-1:0] clamped;
	logic [ADC_BITS-1:0] diff_counts;
	logic [TEMP_W:0]     dh;
	logic                dh_neg;
	logic [TEMP_W:0]     dh_mag;
	logic [TEMP_W:0]     q_map;
	logic [TEMP_W:0]     f_sum;
	logic [ADC_BITS-1:0] moved;
	logic                emit;
	logic [TEMP_W:0]     g;
	logic                g_neg;
	logic [TEMP_W:0]     g_mag;
	logic                out_free;
	logic                load_out;
	logic [TENTHS_W-1:0] tmag_ext;
	logic [TEMP_W-1:0]   whole_ext;

	atr_serial_arith #(
		.W   (W),
		.DVW (DVW)
	) u_arith (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.opnd_a    (opnd_a),
		.opnd_b    (opnd_b),
		.done      (done),
		.quotient  (quot),
		.remainder (rem)
	);

	assign in_accept = in_valid && in_ready;
	assign closing   = idx_q == IDX_W'(SAMPLES - 1);
	assign sum_next  = sum_q + SUM_W'(sample);

	// mapping: clamp, offset, signed span of the temperature range
	assign avg_w       = quot[ADC_BITS-1:0];
	assign span_ok     = adc_max_q > adc_min_q;
	assign span        = adc_max_q - adc_min_q;
	assign clamped     = (avg_w < adc_min_q) ? adc_min_q :
	                     (avg_w > adc_max_q) ? adc_max_q : avg_w;
	assign diff_counts = clamped - adc_min_q;
	assign dh          = {temp_high_q[TEMP_W-1], temp_high_q}
	                     - {temp_low_q[TEMP_W-1], temp_low_q};
	assign dh_neg      = dh[TEMP_W];
	assign dh_mag      = dh_neg ? (~dh + (TEMP_W+1)'(1)) : dh;
	// quotient never exceeds the temperature span, so the low bits suffice
	assign q_map       = quot[TEMP_W:0];
	assign f_sum       = {temp_low_q[TEMP_W-1], temp_low_q}
	                     + (dh_neg ? (~q_map + (TEMP_W+1)'(1)) : q_map);

	// deadband on the unclamped average
	assign moved = (avg_q >= last_counts_q) ? (avg_q - last_counts_q)
	                                        : (last_counts_q - avg_q);
	assign emit  = !emitted_q || ((f_q != last_f_q) && (moved >= deadband_q));

	assign g     = {f_q[TEMP_W-1], f_q} - (TEMP_W+1)'(F_OFFSET);
	assign g_neg = g[TEMP_W];
	assign g_mag = g_neg ? (~g + (TEMP_W+1)'(1)) : g;

	assign out_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_ACC: begin
				if (in_valid && closing) state_nxt = ST_AVG;
			end
			ST_AVG: begin
				if (done) state_nxt = span_ok ? ST_MAP_MUL : ST_DECIDE;
			end
			ST_MAP_MUL: begin
				if (done) state_nxt = ST_MAP_DIV;
			end
			ST_MAP_DIV: begin
				if (done) state_nxt = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_nxt = emit ? ST_TEN_MUL : ST_ACC;
			end
			ST_TEN_MUL: begin
				if (done) state_nxt = ST_TEN_DIV;
			end
			ST_TEN_DIV: begin
				if (done) state_nxt = ST_DIV10;
			end
			ST_DIV10: begin
				if (done) state_nxt = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) state_nxt = ST_ACC;
			end
			default: state_nxt = ST_ACC;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready  = 1'b0;
		ctl.start = 1'b0;
		ctl.op    = OP_DIV;
		opnd_a    = '0;
		opnd_b    = '0;
		load_out  = 1'b0;
		case (state_q)
			ST_ACC: begin
				in_ready = 1'b1;
				if (in_valid && closing) begin
					ctl.start = 1'b1;
					opnd_a    = W'(sum_next);
					opnd_b    = DVW'(SAMPLES);
				end
			end
			ST_AVG: begin
				if (done && span_ok) begin
					ctl.start = 1'b1;
					ctl.op    = OP_MUL;
					opnd_a    = W'(diff_counts);
					opnd_b    = DVW'(dh_mag[TEMP_W-1:0]);
				end
			end
			ST_MAP_MUL: begin
				if (done) begin
					ctl.start = 1'b1;
					opnd_a    = quot;
					opnd_b    = DVW'(span);
				end
			end
			ST_DECIDE: begin
				if (emit) begin
					ctl.start = 1'b1;
					ctl.op    = OP_MUL;
					opnd_a    = W'(g_mag);
					opnd_b    = DVW'(TENTHS_MUL);
				end
			end
			ST_TEN_MUL: begin
				if (done) begin
					ctl.start = 1'b1;
					opnd_a    = quot;
					opnd_b    = DVW'(DIV_NINE);
				end
			end
			ST_TEN_DIV: begin
				if (done) begin
					ctl.start = 1'b1;
					opnd_a    = quot;
					opnd_b    = DVW'(DIV_TEN);
				end
			end
			ST_OUT: begin
				load_out = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q    <= ADC_BITS'(DEADBAND_RST);
			adc_min_q     <= ADC_BITS'(ADC_MIN_RST);
			adc_max_q     <= ADC_BITS'(ADC_MAX_RST);
			temp_low_q    <= TEMP_W'(TEMP_LOW_RST);
			temp_high_q   <= TEMP_W'(TEMP_HIGH_RST);
			state_q       <= ST_ACC;
			sum_q         <= '0;
			idx_q         <= '0;
			last_counts_q <= '0;
			last_f_q      <= '0;
			emitted_q     <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_DEADBAND:  deadband_q  <= cfg_data[ADC_BITS-1:0];
					CFG_ADC_MIN:   adc_min_q   <= cfg_data[ADC_BITS-1:0];
					CFG_ADC_MAX:   adc_max_q   <= cfg_data[ADC_BITS-1:0];
					CFG_TEMP_LOW:  temp_low_q  <= cfg_data[TEMP_W-1:0];
					CFG_TEMP_HIGH: temp_high_q <= cfg_data[TEMP_W-1:0];
					default: ;
				endcase
			end

			state_q <= state_nxt;

			if (in_accept) begin
				if (closing) begin
					sum_q <= '0;
					idx_q <= '0;
				end else begin
					sum_q <= sum_next;
					idx_q <= idx_q + IDX_W'(1);
				end
			end

			if (state_q == ST_DECIDE && emit) begin
				last_counts_q <= avg_q;
				last_f_q      <= f_q;
				emitted_q     <= 1'b1;
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign tmag_ext  = {1'b0, tmag_q};
	assign whole_ext = {1'b0, quot[WHOLE_W-1:0]};

	always_ff @(posedge clk) begin
		if (state_q == ST_AVG && done) begin
			avg_q <= avg_w;
			if (!span_ok) f_q <= temp_low_q;
		end
		if (state_q == ST_MAP_DIV && done) begin
			f_q <= f_sum[TEMP_W-1:0];
		end
		if (state_q == ST_DECIDE && emit) begin
			g_neg_q <= g_neg;
		end
		if (state_q == ST_TEN_DIV && done) begin
			tmag_q <= quot[TMAG_W-1:0];
		end
		if (load_out) begin
			// celsius = tenths / 10 with the sign of the tenths value
			avg_out_q    <= avg_q;
			f_out_q      <= f_q;
			c_out_q      <= g_neg_q ? (~whole_ext + TEMP_W'(1)) : whole_ext;
			tenths_out_q <= g_neg_q ? (~tmag_ext + TENTHS_W'(1)) : tmag_ext;
			tneg_out_q   <= g_neg_q && (tmag_q != '0);
			whole_out_q  <= quot[WHOLE_W-1:0];
			digit_out_q  <= rem[DIGIT_W-1:0];
		end
	end

	assign cfg_ready       = 1'b1;
	assign out_valid       = out_valid_q;
	assign average_counts  = avg_out_q;
	assign fahrenheit      = f_out_q;
	assign celsius         = c_out_q;
	assign celsius_tenths  = tenths_out_q;
	assign tenths_negative = tneg_out_q;
	assign whole_degrees   = whole_out_q;
	assign tenth_digit     = digit_out_q;

	`ATR_ASSERT_NOW(a_no_done_while_sampling, state_q == ST_ACC, !done,
		"serial unit finished while sampling")
	`ATR_ASSERT_NEXT(a_window_restart, in_accept && closing,
		(state_q == ST_AVG) && (idx_q == '0) && (sum_q == '0),
		"window did not restart after its last sample")
	`ATR_ASSERT_NOW(a_f_in_range, state_q == ST_DECIDE,
		((f_q >= temp_low_q) && (f_q <= temp_high_q)) || ((f_q <= temp_low_q) && (f_q >= temp_high_q)),
		"mapped temperature outside the configured range")
	`ATR_ASSERT_NOW(a_sign_matches, out_valid_q,
		tneg_out_q == tenths_out_q[TENTHS_W-1],
		"sign flag disagrees with tenths value")

endmodule

`default_nettype wire
